// ----- src/cltc_pkg.sv -----
// Shared types and constants for the calorimeter tower cluster core.
`default_nettype none

package cltc_pkg;

	localparam int ENERGY_BITS_DEF = 10;
	localparam int FIELD_E_BITS    = 10;
	localparam int FIELD_T_BITS    = 3;
	localparam int BIN_BITS        = 3;
	localparam int NUM_PHI         = 5;
	localparam int NUM_ETA         = 5;
	localparam int ROW_BITS        = 3;
	localparam logic [ROW_BITS-1:0] LAST_ROW = 3'd4;
	localparam int unsigned SAT16  = 32'hFFFF;
	localparam int unsigned SAT10  = 32'h3FF;

	typedef struct packed {
		logic [FIELD_E_BITS-1:0] energy_phi0;
		logic [FIELD_E_BITS-1:0] energy_phi1;
		logic [FIELD_E_BITS-1:0] energy_phi2;
		logic [FIELD_E_BITS-1:0] energy_phi3;
		logic [FIELD_E_BITS-1:0] energy_phi4;
		logic [FIELD_T_BITS-1:0] time_phi0;
		logic [FIELD_T_BITS-1:0] time_phi1;
		logic [FIELD_T_BITS-1:0] time_phi2;
		logic [FIELD_T_BITS-1:0] time_phi3;
		logic [FIELD_T_BITS-1:0] time_phi4;
	} crystal_row_t;

	typedef struct packed {
		logic [FIELD_E_BITS-1:0] cluster_energy;
		logic [FIELD_E_BITS-1:0] tower_energy;
		logic [BIN_BITS-1:0]     peak_phi_bin;
		logic [BIN_BITS-1:0]     peak_eta_bin;
		logic [FIELD_T_BITS-1:0] peak_time_value;
		logic [FIELD_T_BITS-1:0] hadronic_ratio;
	} tower_t;

	// Per-row control that the merge stage hands to every phi lane.
	typedef struct packed {
		logic                load;
		logic                clear;
		logic [ROW_BITS-1:0] row;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ----- src/cltc_lane.sv -----
// One phi column: accumulates the phi strip sum and keeps the five crystal times.
`default_nettype none

module cltc_lane
	import cltc_pkg::*;
#(
	parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lane_ctl_t                ctl,
	input  wire logic [ENERGY_BITS-1:0]   energy,
	input  wire logic [FIELD_T_BITS-1:0]  crystal_time,
	input  wire logic [BIN_BITS-1:0]      rd_row,
	output logic [ENERGY_BITS+2:0]        phi_sum,
	output logic [FIELD_T_BITS-1:0]       rd_time
);

	localparam int SW = ENERGY_BITS + 3;

	logic [SW-1:0]           phi_q;
	logic [FIELD_T_BITS-1:0] time_q [NUM_ETA];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phi_q <= '0;
		end else if (ctl.clear) begin
			phi_q <= '0;
		end else if (ctl.load) begin
			phi_q <= phi_q + SW'(energy);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			time_q[ctl.row] <= crystal_time;
		end
	end

	assign phi_sum = phi_q;
	assign rd_time = time_q[rd_row];

endmodule

`default_nettype wire

// ----- src/cltc_merge.sv -----
// Row counter, eta strip store and the three-stage tower computation.
`default_nettype none

module cltc_merge
	import cltc_pkg::*;
#(
	parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic [ENERGY_BITS-1:0]  energy [NUM_PHI],
	input  wire logic [ENERGY_BITS+2:0]  phi_sum [NUM_PHI],
	input  wire logic [FIELD_T_BITS-1:0] lane_time [NUM_PHI],
	output lane_ctl_t                    ctl,
	output logic [BIN_BITS-1:0]          rd_row,
	output logic                         busy,
	output logic                         done,
	output tower_t                       tower
);

	localparam int SW = ENERGY_BITS + 3;
	localparam int TW = SW + 3;
	localparam int CW = (SW + 5 > 17) ? SW + 5 : 17;

	logic [ROW_BITS-1:0] row_q;
	logic [SW-1:0]       eta_q [NUM_ETA];
	logic [SW-1:0]       row_sum;
	logic                go_q;
	logic                valid_s1;
	logic                valid_s2;
	logic                done_q;
	logic [TW-1:0]       total;
	logic [TW-1:0]       total_s1;
	logic [CW-1:0]       weta_s1;
	logic [CW-1:0]       wphi_s1;
	logic [BIN_BITS-1:0] pe_s2;
	logic [BIN_BITS-1:0] pp_s2;
	logic [FIELD_E_BITS-1:0] tsat_s2;
	logic [TW-1:0]       cluster;
	tower_t              tower_q;

	// Weighted strip position with bin centers at 0.5 .. 4.5, halves floored.
	function automatic logic [CW-1:0] wsum(input logic [SW-1:0] s [NUM_PHI]);
		logic [CW-1:0] w;
		w = CW'(s[0] >> 1)
			+ CW'(s[1]) + CW'(s[1] >> 1)
			+ (CW'(s[2]) << 1) + CW'(s[2] >> 1)
			+ (CW'(s[3]) << 2) - CW'(s[3] >> 1)
			+ (CW'(s[4]) << 2) + CW'(s[4] >> 1);
		return (w > CW'(SAT16)) ? CW'(SAT16) : w;
	endfunction

	function automatic logic [BIN_BITS-1:0] peak(input logic [CW-1:0] w,
			input logic [TW-1:0] t);
		logic [CW-1:0] t1;
		logic [CW-1:0] t2;
		logic [CW-1:0] t3;
		logic [CW-1:0] t4;
		t1 = CW'(t);
		t2 = t1 << 1;
		t3 = t2 + t1;
		t4 = t1 << 2;
		if (w <= t1)      return 3'd0;
		else if (w <= t2) return 3'd1;
		else if (w <= t3) return 3'd2;
		else if (w <= t4) return 3'd3;
		else              return 3'd4;
	endfunction

	always_comb begin
		row_sum = '0;
		for (int i = 0; i < NUM_PHI; i++) begin
			row_sum = row_sum + SW'(energy[i]);
		end
		total = '0;
		for (int i = 0; i < NUM_ETA; i++) begin
			total = total + TW'(eta_q[i]);
		end
		// Cluster takes the peak strip and its neighbors that exist.
		cluster = '0;
		for (int i = 0; i < NUM_ETA; i++) begin
			if ((i + 1 >= int'(pe_s2)) && (i <= int'(pe_s2) + 1)) begin
				cluster = cluster + TW'(eta_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			go_q     <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (accept) begin
				row_q <= (row_q == LAST_ROW) ? '0 : row_q + 1'b1;
			end
			go_q     <= accept && (row_q == LAST_ROW);
			valid_s1 <= go_q;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eta_q[row_q] <= row_sum;
		end
		if (go_q) begin
			total_s1 <= total;
			weta_s1  <= wsum(eta_q);
			wphi_s1  <= wsum(phi_sum);
		end
		if (valid_s1) begin
			pe_s2   <= peak(weta_s1, total_s1);
			pp_s2   <= peak(wphi_s1, total_s1);
			tsat_s2 <= (total_s1 > TW'(SAT10)) ? FIELD_E_BITS'(SAT10)
				: total_s1[FIELD_E_BITS-1:0];
		end
		if (valid_s2) begin
			tower_q.cluster_energy  <= (cluster > TW'(SAT10)) ? FIELD_E_BITS'(SAT10)
				: cluster[FIELD_E_BITS-1:0];
			tower_q.tower_energy    <= tsat_s2;
			tower_q.peak_phi_bin    <= pp_s2;
			tower_q.peak_eta_bin    <= pe_s2;
			// Times sit at row*5+phi and are read at phi_bin*5+eta_bin.
			tower_q.peak_time_value <= lane_time[pe_s2];
			tower_q.hadronic_ratio  <= '0;
		end
	end

	assign ctl.load  = accept;
	assign ctl.clear = go_q;
	assign ctl.row   = row_q;
	assign rd_row    = pp_s2;
	assign busy      = go_q | valid_s1 | valid_s2;
	assign done      = done_q;
	assign tower     = tower_q;

endmodule

`default_nettype wire

// ----- src/calorimeter_tower_cluster_core.sv -----
// Top level of the calorimeter tower cluster core: five phi lanes and the merge stage.
//
// Usage: a 5x5 crystal grid arrives as five words on crystal_row, one eta row
// per word, each taken at a rising edge where start is high and busy is low.
// Every phi lane adds its crystal energy to its phi strip sum and keeps the
// crystal time; the merge stage adds the row into an eta strip sum.
// Rows one to four give no result and busy stays low, so rows can come every
// cycle. The fifth row raises busy while the tower pipeline runs its stages
// (strip weights and total, peak bins, cluster sum and time lookup).
// When busy falls, done is high for one cycle with the word on tower; busy is
// already low then, so the next grid may start in that cycle.
// A tower therefore takes five row words and the busy period.
// The receiver cannot stall; it must take the tower word while done is high.
// Reset (arst_n low) clears the row count, the phi strip sums and the
// pipeline flags; the block then waits for the first row of a new grid.
`default_nettype none

module calorimeter_tower_cluster_core
	import cltc_pkg::*;
#(
	parameter int ENERGY_BITS = ENERGY_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire crystal_row_t crystal_row,
	output logic              done,
	output tower_t            tower
);

	localparam int SW = ENERGY_BITS + 3;

	logic                    accept;
	lane_ctl_t               ctl;
	logic [BIN_BITS-1:0]     rd_row;
	logic [ENERGY_BITS-1:0]  lane_energy [NUM_PHI];
	logic [FIELD_T_BITS-1:0] lane_tin [NUM_PHI];
	logic [SW-1:0]           phi_sum [NUM_PHI];
	logic [FIELD_T_BITS-1:0] lane_time [NUM_PHI];

	assign accept = start & ~busy;

	// Only the low ENERGY_BITS bits of each crystal energy count.
	assign lane_energy[0] = crystal_row.energy_phi0[ENERGY_BITS-1:0];
	assign lane_energy[1] = crystal_row.energy_phi1[ENERGY_BITS-1:0];
	assign lane_energy[2] = crystal_row.energy_phi2[ENERGY_BITS-1:0];
	assign lane_energy[3] = crystal_row.energy_phi3[ENERGY_BITS-1:0];
	assign lane_energy[4] = crystal_row.energy_phi4[ENERGY_BITS-1:0];
	assign lane_tin[0]    = crystal_row.time_phi0;
	assign lane_tin[1]    = crystal_row.time_phi1;
	assign lane_tin[2]    = crystal_row.time_phi2;
	assign lane_tin[3]    = crystal_row.time_phi3;
	assign lane_tin[4]    = crystal_row.time_phi4;

	for (genvar g = 0; g < NUM_PHI; g++) begin : g_lane
		cltc_lane #(
			.ENERGY_BITS(ENERGY_BITS)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.energy      (lane_energy[g]),
			.crystal_time(lane_tin[g]),
			.rd_row      (rd_row),
			.phi_sum     (phi_sum[g]),
			.rd_time     (lane_time[g])
		);
	end

	cltc_merge #(
		.ENERGY_BITS(ENERGY_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.energy   (lane_energy),
		.phi_sum  (phi_sum),
		.lane_time(lane_time),
		.ctl      (ctl),
		.rd_row   (rd_row),
		.busy     (busy),
		.done     (done),
		.tower    (tower)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_calorimeter_tower_cluster_core.sv -----
// Self-checking testbench for the calorimeter tower cluster core: directed grids, then random grids.
module tb_calorimeter_tower_cluster_core;
	import cltc_pkg::*;

	localparam int EBITS = ENERGY_BITS_DEF;
	localparam logic [FIELD_E_BITS-1:0] EMASK = FIELD_E_BITS'((1 << EBITS) - 1);
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_GRIDS = 235;
	localparam int TAIL_CYCLES = 8;

	typedef struct {
		crystal_row_t word;
		bit           typed;
		tower_t       tower;
	} directed_word_t;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	crystal_row_t crystal_row;
	logic         done;
	tower_t       tower;

	// Model of the grid accumulator.
	int unsigned       grid_row = 0;
	logic [12:0]       eta_sums [5];
	logic [12:0]       phi_sums [5] = '{default: '0};
	logic [2:0]        time_grid [25];

	tower_t            pending_towers [$];
	directed_word_t    directed [$];
	int unsigned       mismatches = 0;
	int unsigned       stall_cycles = 0;
	bit                quiet = 0;

	calorimeter_tower_cluster_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.crystal_row(crystal_row),
		.done       (done),
		.tower      (tower)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic crystal_row_t make_row(input int e0, e1, e2, e3, e4,
			input int t0, t1, t2, t3, t4);
		crystal_row_t r;
		r.energy_phi0 = e0[FIELD_E_BITS-1:0];
		r.energy_phi1 = e1[FIELD_E_BITS-1:0];
		r.energy_phi2 = e2[FIELD_E_BITS-1:0];
		r.energy_phi3 = e3[FIELD_E_BITS-1:0];
		r.energy_phi4 = e4[FIELD_E_BITS-1:0];
		r.time_phi0   = t0[FIELD_T_BITS-1:0];
		r.time_phi1   = t1[FIELD_T_BITS-1:0];
		r.time_phi2   = t2[FIELD_T_BITS-1:0];
		r.time_phi3   = t3[FIELD_T_BITS-1:0];
		r.time_phi4   = t4[FIELD_T_BITS-1:0];
		return r;
	endfunction

	function automatic tower_t make_tower(input int ce, te, pp, pe, pt);
		tower_t t;
		t.cluster_energy  = ce[FIELD_E_BITS-1:0];
		t.tower_energy    = te[FIELD_E_BITS-1:0];
		t.peak_phi_bin    = pp[BIN_BITS-1:0];
		t.peak_eta_bin    = pe[BIN_BITS-1:0];
		t.peak_time_value = pt[FIELD_T_BITS-1:0];
		t.hadronic_ratio  = '0;
		return t;
	endfunction

	function automatic directed_word_t dw(input crystal_row_t w, input bit typed = 0,
			input tower_t t = '0);
		directed_word_t d;
		d.word  = w;
		d.typed = typed;
		d.tower = t;
		return d;
	endfunction

	// Weighted strip position against multiples of the total; half weights are floored.
	function automatic int unsigned peak_position(input logic [12:0] s [5],
			input int unsigned total);
		longint unsigned v [5];
		longint unsigned w;
		longint unsigned t;
		for (int i = 0; i < 5; i++)
			v[i] = s[i];
		t = total;
		w = (v[0] >> 1) + v[1] + (v[1] >> 1) + (v[2] << 1) + (v[2] >> 1)
			+ (v[3] << 2) - (v[3] >> 1) + (v[4] << 2) + (v[4] >> 1);
		if (w > SAT16)
			w = SAT16;
		if (w <= t)
			return 0;
		if (w <= 2 * t)
			return 1;
		if (w <= 3 * t)
			return 2;
		if (w <= 4 * t)
			return 3;
		return 4;
	endfunction

	task automatic absorb_row(input crystal_row_t r, output bit emits, output tower_t t);
		logic [FIELD_E_BITS-1:0] e [5];
		logic [FIELD_T_BITS-1:0] tm [5];
		int unsigned rsum;
		int unsigned total;
		int unsigned cluster;
		int unsigned row;
		int unsigned pe;
		int unsigned pp;
		e = '{r.energy_phi0, r.energy_phi1, r.energy_phi2, r.energy_phi3, r.energy_phi4};
		tm = '{r.time_phi0, r.time_phi1, r.time_phi2, r.time_phi3, r.time_phi4};
		rsum = 0;
		total = 0;
		cluster = 0;
		t = '0;
		row = grid_row;
		if (row > LAST_ROW)
			row = 0;
		for (int i = 0; i < 5; i++) begin
			rsum += e[i] & EMASK;
			phi_sums[i] = phi_sums[i] + (e[i] & EMASK);
			time_grid[row * 5 + i] = tm[i];
		end
		eta_sums[row] = rsum[12:0];
		if (row < LAST_ROW) begin
			grid_row = row + 1;
			emits = 0;
		end else begin
			for (int i = 0; i < 5; i++)
				total += eta_sums[i];
			pe = peak_position(eta_sums, total);
			pp = peak_position(phi_sums, total);
			// Cluster takes the peak eta strip and its neighbors that exist.
			for (int i = 0; i < 5; i++)
				if (i + 1 >= pe && i <= pe + 1)
					cluster += eta_sums[i];
			t = make_tower(cluster > SAT10 ? SAT10 : cluster, total > SAT10 ? SAT10 : total,
				pp, pe, time_grid[(pp * 5 + pe) % 25]);
			grid_row = 0;
			for (int i = 0; i < 5; i++)
				phi_sums[i] = '0;
			emits = 1;
		end
	endtask

	// Holds start high until the word is taken; start is left high for the caller.
	task automatic put_row(input crystal_row_t r, input bit typed = 0,
			input tower_t fixed = '0);
		bit emits;
		tower_t t;
		start <= 1'b1;
		crystal_row <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		absorb_row(r, emits, t);
		if (emits)
			pending_towers.push_back(typed ? fixed : t);
	endtask

	task automatic idle_gap();
		logic [95:0] junk;
		if (!quiet && $urandom_range(99) < 37) begin
			junk = {$urandom, $urandom, $urandom};
			start <= 1'b0;
			crystal_row <= junk[$bits(crystal_row_t)-1:0];
			do
				@(posedge clk);
			while ($urandom_range(99) < 37);
		end
	endtask

	function automatic int grid_energy(input int mode, input int r, input int p,
			input int ce, input int cp, input int peak);
		int d;
		case (mode)
			0: return ($urandom_range(99) < 80) ? 0 : $urandom_range(1023);
			1: return $urandom_range(1023);
			2: return $urandom_range(15);
			3: return 1023 - $urandom_range(7);
			default: begin
				d = (r > ce ? r - ce : ce - r) + (p > cp ? p - cp : cp - p);
				return (peak >> (2 * d)) + $urandom_range(3);
			end
		endcase
	endfunction

	task automatic send_random_grid();
		int mode;
		int ce;
		int cp;
		int peak;
		int e [5];
		mode = $urandom_range(4);
		ce = $urandom_range(4);
		cp = $urandom_range(4);
		peak = $urandom_range(1020);
		for (int r = 0; r < 5; r++) begin
			for (int p = 0; p < 5; p++)
				e[p] = grid_energy(mode, r, p, ce, cp, peak);
			idle_gap();
			put_row(make_row(e[0], e[1], e[2], e[3], e[4],
				$urandom_range(7), $urandom_range(7), $urandom_range(7),
				$urandom_range(7), $urandom_range(7)));
		end
	endtask

	task automatic check_tower(input tower_t got);
		tower_t want;
		bit bad;
		if (pending_towers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("tower word with none expected: ");
				$display("ce=%0d te=%0d phi=%0d eta=%0d t=%0d h=%0d",
					got.cluster_energy, got.tower_energy, got.peak_phi_bin,
					got.peak_eta_bin, got.peak_time_value, got.hadronic_ratio);
			end
		end else begin
			want = pending_towers.pop_front();
			bad = (got.cluster_energy !== want.cluster_energy)
				|| (got.tower_energy !== want.tower_energy)
				|| (got.peak_phi_bin !== want.peak_phi_bin)
				|| (got.peak_eta_bin !== want.peak_eta_bin)
				|| (got.peak_time_value !== want.peak_time_value)
				|| (got.hadronic_ratio !== want.hadronic_ratio);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$write("tower mismatch: expected ce=%0d te=%0d phi=%0d eta=%0d t=%0d h=%0d, ",
						want.cluster_energy, want.tower_energy, want.peak_phi_bin,
						want.peak_eta_bin, want.peak_time_value, want.hadronic_ratio);
					$display("got ce=%0d te=%0d phi=%0d eta=%0d t=%0d h=%0d",
						got.cluster_energy, got.tower_energy, got.peak_phi_bin,
						got.peak_eta_bin, got.peak_time_value, got.hadronic_ratio);
				end
			end
		end
	endtask

	// Values read here are those from before the edge, since the block updates
	// with nonblocking writes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				check_tower(tower);
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("calorimeter_tower_cluster_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		crystal_row_t zero_row;
		crystal_row_t hot_row;
		zero_row = make_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		hot_row = make_row(1023, 1023, 1023, 1023, 1023, 7, 7, 7, 7, 7);

		// Empty grid: both peaks fall to bin zero.
		for (int i = 0; i < 5; i++)
			directed.push_back(dw(zero_row, i == 4, make_tower(0, 0, 0, 0, 0)));
		// Full-scale grid: both energies saturate.
		for (int i = 0; i < 5; i++)
			directed.push_back(dw(hot_row, i == 4, make_tower(1023, 1023, 2, 2, 7)));
		// Single crystal in the low corner: peak at the lower edge.
		directed.push_back(dw(make_row(1023, 0, 0, 0, 0, 5, 0, 0, 0, 0)));
		for (int i = 1; i < 5; i++)
			directed.push_back(dw(zero_row, i == 4, make_tower(1023, 1023, 0, 0, 5)));
		// Single crystal in the high corner: peak at the upper edge.
		for (int i = 0; i < 4; i++)
			directed.push_back(dw(zero_row));
		directed.push_back(dw(make_row(0, 0, 0, 0, 1023, 0, 0, 0, 0, 3), 1,
			make_tower(1023, 1023, 4, 4, 3)));
		// Off-center shower with varied crystal times.
		directed.push_back(dw(make_row(10, 20, 30, 40, 5, 1, 2, 3, 4, 5)));
		directed.push_back(dw(make_row(100, 200, 300, 900, 50, 6, 7, 0, 1, 2)));
		directed.push_back(dw(make_row(30, 60, 90, 120, 15, 3, 4, 5, 6, 7)));
		directed.push_back(dw(make_row(0, 0, 0, 0, 0, 7, 7, 7, 7, 7)));
		directed.push_back(dw(make_row(1, 2, 3, 4, 1023, 0, 1, 0, 1, 0)));

		arst_n = 1'b0;
		start = 1'b0;
		crystal_row = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			idle_gap();
			put_row(directed[k].word, directed[k].typed, directed[k].tower);
		end

		for (int g = 0; g < RANDOM_GRIDS; g++) begin
			quiet = (g >= 80 && g < 130);
			if (g == 60) begin
				// Let the pipeline drain completely before the next grid.
				start <= 1'b0;
				while (pending_towers.size() != 0)
					@(posedge clk);
			end
			send_random_grid();
		end

		start <= 1'b0;
		while (pending_towers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_towers.size() == 0)
			$display("calorimeter_tower_cluster_core regression: pass");
		else
			$display("calorimeter_tower_cluster_core regression: fail");
		$finish;
	end

endmodule
